### rtl/core/tpcr_pkg.sv
// shared types and constants for the three-phase per-cycle rms block
`default_nettype none

package tpcr_pkg;

    localparam int FIELD_BITS      = 16;
    localparam int RMS_BITS        = 16;
    localparam int COUNT_OUT_BITS  = 13;
    localparam int SUM_BITS        = 43;
    localparam int CHANNELS        = 6;
    localparam int CH_BITS         = $clog2(CHANNELS);
    localparam int ROOT_IN_BITS    = SUM_BITS + (SUM_BITS % 2);
    localparam int ROOT_STEPS      = ROOT_IN_BITS / 2;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_WINDOW_DEF  = 4096;

    localparam logic [FIELD_BITS-1:0] THRESHOLD_RESET = 16'd32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_EMIT,
        ST_SQ_LOAD,
        ST_SQUARE,
        ST_SQ_NEXT,
        ST_FINISH
    } top_state_t;

    typedef enum logic [1:0] {
        RMS_IDLE,
        RMS_DIV,
        RMS_ROOT,
        RMS_DONE
    } rms_state_t;

endpackage

`default_nettype wire

### rtl/core/tpcr_if.sv
// channel interfaces: sample beats, result beats, threshold writes
`default_nettype none

interface tpcr_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [tpcr_pkg::FIELD_BITS-1:0]        phase_angle;
    logic signed [tpcr_pkg::FIELD_BITS-1:0] current_a;
    logic signed [tpcr_pkg::FIELD_BITS-1:0] current_b;
    logic signed [tpcr_pkg::FIELD_BITS-1:0] current_c;
    logic signed [tpcr_pkg::FIELD_BITS-1:0] voltage_a;
    logic signed [tpcr_pkg::FIELD_BITS-1:0] voltage_b;
    logic signed [tpcr_pkg::FIELD_BITS-1:0] voltage_c;

    modport source (
        output valid, phase_angle, current_a, current_b, current_c,
               voltage_a, voltage_b, voltage_c,
        input  ready
    );
    modport sink (
        input  valid, phase_angle, current_a, current_b, current_c,
               voltage_a, voltage_b, voltage_c,
        output ready
    );
endinterface

interface tpcr_out_if;
    logic                                valid;
    logic                                ready;
    logic [tpcr_pkg::RMS_BITS-1:0]       rms_current_a;
    logic [tpcr_pkg::RMS_BITS-1:0]       rms_current_b;
    logic [tpcr_pkg::RMS_BITS-1:0]       rms_current_c;
    logic [tpcr_pkg::RMS_BITS-1:0]       rms_voltage_a;
    logic [tpcr_pkg::RMS_BITS-1:0]       rms_voltage_b;
    logic [tpcr_pkg::RMS_BITS-1:0]       rms_voltage_c;
    logic [tpcr_pkg::COUNT_OUT_BITS-1:0] window_samples;

    modport source (
        output valid, rms_current_a, rms_current_b, rms_current_c,
               rms_voltage_a, rms_voltage_b, rms_voltage_c, window_samples,
        input  ready
    );
    modport sink (
        input  valid, rms_current_a, rms_current_b, rms_current_c,
               rms_voltage_a, rms_voltage_b, rms_voltage_c, window_samples,
        output ready
    );
endinterface

interface tpcr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tpcr_pkg::FIELD_BITS-1:0] wrap_drop_threshold;

    modport source (
        output valid, wrap_drop_threshold,
        input  ready
    );
    modport sink (
        input  valid, wrap_drop_threshold,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/three_phase_cycle_rms.sv
// top level: per-cycle true rms of three currents and three voltages
//
//  channel   dir   payload                                          handshake
//  sample    in    phase_angle, current_a..c, voltage_a..c          valid/ready
//  result    out   rms_current_a..c, rms_voltage_a..c, window_samples valid/ready
//  cfg       in    wrap_drop_threshold                              valid/ready
//
//  a beat without a wrap is squared channel by channel (serial squaring)
//  a wrap beat adds a divide and root per channel: one shared divide/root unit, one bit per cycle
//  result sits in an output register; a new sample is taken while it waits
//  a second wrap stalls until the previous result is taken
//  reset: threshold 32768, angle, sums and count zero; cfg always ready
`default_nettype none

module three_phase_cycle_rms #(
    parameter int SAMPLE_BITS = tpcr_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW  = tpcr_pkg::MAX_WINDOW_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tpcr_in_if.sink   sample,
    tpcr_out_if.source result,
    tpcr_cfg_if.sink  cfg
);

    localparam int FW        = tpcr_pkg::FIELD_BITS;
    localparam int CH        = tpcr_pkg::CHANNELS;
    localparam int SB        = tpcr_pkg::SUM_BITS;
    localparam int RB        = tpcr_pkg::RMS_BITS;
    localparam int WB        = tpcr_pkg::COUNT_OUT_BITS;
    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int ACC_BITS  = ((SB > PROD_BITS) ? SB : PROD_BITS) + 1;
    localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SQ_BITS   = $clog2(SAMPLE_BITS);

    tpcr_pkg::top_state_t state_reg, state_next;

    logic [FW-1:0]              thresh_reg;
    logic [FW-1:0]              last_angle_reg;
    logic [FW-1:0]              last_angle_reg_hold;
    logic [CNT_BITS-1:0]        count_reg;
    logic [SB-1:0]              sums_reg [CH];
    logic [SAMPLE_BITS-1:0]     mag_reg [CH];
    logic [RB-1:0]              res_reg [CH];
    logic [tpcr_pkg::CH_BITS-1:0] ch_reg;
    logic [SQ_BITS-1:0]         sq_step_reg;
    logic [PROD_BITS-1:0]       mcand_reg;
    logic [SAMPLE_BITS-1:0]     mplier_reg;

    logic                       out_valid_reg;
    logic [RB-1:0]              out_rms_reg [CH];
    logic [WB-1:0]              out_count_reg;

    logic [FW-1:0]              raw [CH];
    logic [FW+SAMPLE_BITS-1:0]  raw_wide [CH];
    logic [SAMPLE_BITS-1:0]     raw_val [CH];
    logic [SAMPLE_BITS-1:0]     mag [CH];
    logic [FW:0]                angle_diff;
    logic                       close_now;
    logic [CNT_BITS-1:0]        divisor;
    logic [CNT_BITS+WB-1:0]     divisor_wide;
    logic [ACC_BITS-1:0]        sum_acc;
    logic [SB-1:0]              sum_add;
    logic                       ch_last;
    logic                       sq_last;
    logic                       accept;

    logic                       take_beat;
    logic                       root_start;
    logic                       emit_en;
    logic                       root_done;
    logic [RB-1:0]              root_value;

    assign cfg.ready = 1'b1;
    assign accept    = sample.valid && sample.ready;

    assign raw[0] = $unsigned(sample.current_a);
    assign raw[1] = $unsigned(sample.current_b);
    assign raw[2] = $unsigned(sample.current_c);
    assign raw[3] = $unsigned(sample.voltage_a);
    assign raw[4] = $unsigned(sample.voltage_b);
    assign raw[5] = $unsigned(sample.voltage_c);

    // magnitude of the low SAMPLE_BITS bits taken as two's complement
    always_comb
    begin
        for (int i = 0; i < CH; i++)
        begin
            raw_wide[i] = {SAMPLE_BITS'(0), raw[i]};
            raw_val[i]  = raw_wide[i][SAMPLE_BITS-1:0];
            mag[i]      = raw_val[i][SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw_val[i] + 1'b1)
                                                    : raw_val[i];
        end
    end

    assign angle_diff = {1'b0, last_angle_reg} - {1'b0, sample.phase_angle};
    assign close_now  = !angle_diff[FW] && (angle_diff[FW-1:0] > thresh_reg);

    assign divisor      = (count_reg == '0) ? CNT_BITS'(1) : count_reg;
    assign divisor_wide = {WB'(0), divisor};

    assign sum_acc = ACC_BITS'(sums_reg[0]) + ACC_BITS'(mcand_reg);
    assign sum_add = (sum_acc > ACC_BITS'({SB{1'b1}})) ? {SB{1'b1}} : sum_acc[SB-1:0];

    assign ch_last = (ch_reg == tpcr_pkg::CH_BITS'(CH - 1));
    assign sq_last = (sq_step_reg == '0);

    tpcr_rms_unit #(
        .CNT_BITS (CNT_BITS)
    ) u_rms (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .dividend (sums_reg[0]),
        .divisor  (divisor),
        .done     (root_done),
        .root     (root_value)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tpcr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = close_now ? tpcr_pkg::ST_ROOT_START : tpcr_pkg::ST_SQ_LOAD;
                end
            end
            tpcr_pkg::ST_ROOT_START:
            begin
                state_next = tpcr_pkg::ST_ROOT_WAIT;
            end
            tpcr_pkg::ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    state_next = ch_last ? tpcr_pkg::ST_EMIT : tpcr_pkg::ST_ROOT_START;
                end
            end
            tpcr_pkg::ST_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = tpcr_pkg::ST_SQ_LOAD;
                end
            end
            tpcr_pkg::ST_SQ_LOAD:
            begin
                state_next = tpcr_pkg::ST_SQUARE;
            end
            tpcr_pkg::ST_SQUARE:
            begin
                if (sq_last)
                begin
                    state_next = tpcr_pkg::ST_SQ_NEXT;
                end
            end
            tpcr_pkg::ST_SQ_NEXT:
            begin
                state_next = ch_last ? tpcr_pkg::ST_FINISH : tpcr_pkg::ST_SQ_LOAD;
            end
            tpcr_pkg::ST_FINISH:
            begin
                state_next = tpcr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tpcr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        take_beat  = 1'b0;
        root_start = 1'b0;
        emit_en    = 1'b0;
        case (state_reg)
            tpcr_pkg::ST_IDLE:       take_beat  = 1'b1;
            tpcr_pkg::ST_ROOT_START: root_start = 1'b1;
            tpcr_pkg::ST_EMIT:       emit_en    = !out_valid_reg;
            default:                 take_beat  = 1'b0;
        endcase
    end

    assign sample.ready = take_beat;

    assign result.valid          = out_valid_reg;
    assign result.rms_current_a  = out_rms_reg[0];
    assign result.rms_current_b  = out_rms_reg[1];
    assign result.rms_current_c  = out_rms_reg[2];
    assign result.rms_voltage_a  = out_rms_reg[3];
    assign result.rms_voltage_b  = out_rms_reg[4];
    assign result.rms_voltage_c  = out_rms_reg[5];
    assign result.window_samples = out_count_reg;

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tpcr_pkg::ST_IDLE;
            thresh_reg     <= tpcr_pkg::THRESHOLD_RESET;
            last_angle_reg <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            ch_reg         <= '0;
            for (int i = 0; i < CH; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                thresh_reg <= cfg.wrap_drop_threshold;
            end

            if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                tpcr_pkg::ST_IDLE:
                begin
                    ch_reg <= '0;
                end
                tpcr_pkg::ST_ROOT_WAIT:
                begin
                    if (root_done)
                    begin
                        // rotate, clearing the closed sum on the way
                        for (int i = 0; i < CH - 1; i++)
                        begin
                            sums_reg[i] <= sums_reg[i+1];
                        end
                        sums_reg[CH-1] <= '0;
                        ch_reg <= ch_last ? '0 : ch_reg + 1'b1;
                    end
                end
                tpcr_pkg::ST_EMIT:
                begin
                    if (emit_en)
                    begin
                        out_valid_reg <= 1'b1;
                        count_reg     <= '0;
                    end
                end
                tpcr_pkg::ST_SQUARE:
                begin
                    if (mplier_reg[0])
                    begin
                        sums_reg[0] <= sum_add;
                    end
                end
                tpcr_pkg::ST_SQ_NEXT:
                begin
                    for (int i = 0; i < CH - 1; i++)
                    begin
                        sums_reg[i] <= sums_reg[i+1];
                    end
                    sums_reg[CH-1] <= sums_reg[0];
                    ch_reg <= ch_last ? '0 : ch_reg + 1'b1;
                end
                tpcr_pkg::ST_FINISH:
                begin
                    if (count_reg < CNT_BITS'(MAX_WINDOW))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    // angle of the beat in flight becomes the reference once its sums are in
                    last_angle_reg <= last_angle_reg_hold;
                end
                default:
                begin
                    ch_reg <= ch_reg;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tpcr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    last_angle_reg_hold <= sample.phase_angle;
                    for (int i = 0; i < CH; i++)
                    begin
                        mag_reg[i] <= mag[i];
                    end
                end
            end
            tpcr_pkg::ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    for (int i = 0; i < CH - 1; i++)
                    begin
                        res_reg[i] <= res_reg[i+1];
                    end
                    res_reg[CH-1] <= root_value;
                end
            end
            tpcr_pkg::ST_EMIT:
            begin
                if (emit_en)
                begin
                    for (int i = 0; i < CH; i++)
                    begin
                        out_rms_reg[i] <= res_reg[i];
                    end
                    out_count_reg <= divisor_wide[WB-1:0];
                end
            end
            tpcr_pkg::ST_SQ_LOAD:
            begin
                mcand_reg   <= PROD_BITS'(mag_reg[0]);
                mplier_reg  <= mag_reg[0];
                sq_step_reg <= SQ_BITS'(SAMPLE_BITS - 1);
            end
            tpcr_pkg::ST_SQUARE:
            begin
                mcand_reg   <= {mcand_reg[PROD_BITS-2:0], 1'b0};
                mplier_reg  <= {1'b0, mplier_reg[SAMPLE_BITS-1:1]};
                sq_step_reg <= sq_step_reg - 1'b1;
            end
            tpcr_pkg::ST_SQ_NEXT:
            begin
                for (int i = 0; i < CH - 1; i++)
                begin
                    mag_reg[i] <= mag_reg[i+1];
                end
                mag_reg[CH-1] <= mag_reg[0];
            end
            default:
            begin
                sq_step_reg <= sq_step_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/tpcr_rms_unit.sv
// bit-serial divide of a square sum by the sample count, then digit-serial square root
`default_nettype none

module tpcr_rms_unit #(
    parameter int CNT_BITS = 13
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [tpcr_pkg::SUM_BITS-1:0]     dividend,
    input  wire logic [CNT_BITS-1:0]               divisor,
    output logic                                   done,
    output logic [tpcr_pkg::RMS_BITS-1:0]          root
);

    localparam int IN_BITS   = tpcr_pkg::ROOT_IN_BITS;
    localparam int RS        = tpcr_pkg::ROOT_STEPS;
    localparam int STEP_BITS = $clog2(IN_BITS);

    tpcr_pkg::rms_state_t state_reg, state_next;

    logic [IN_BITS-1:0]   q_reg;
    logic [CNT_BITS-1:0]  drem_reg;
    logic [CNT_BITS-1:0]  dsor_reg;
    logic [RS+1:0]        srem_reg;
    logic [RS-1:0]        root_reg;
    logic [STEP_BITS-1:0] step_reg;

    logic                 div_en;
    logic                 root_en;
    logic                 step_last;

    logic [CNT_BITS:0]    div_shift;
    logic                 div_ge;
    logic [CNT_BITS:0]    div_diff;
    logic [RS+3:0]        root_shift;
    logic [RS+3:0]        root_trial;
    logic                 root_ge;
    logic [RS+3:0]        root_diff;

    assign step_last = (step_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tpcr_pkg::RMS_IDLE:
            begin
                if (start)
                begin
                    state_next = tpcr_pkg::RMS_DIV;
                end
            end
            tpcr_pkg::RMS_DIV:
            begin
                if (step_last)
                begin
                    state_next = tpcr_pkg::RMS_ROOT;
                end
            end
            tpcr_pkg::RMS_ROOT:
            begin
                if (step_last)
                begin
                    state_next = tpcr_pkg::RMS_DONE;
                end
            end
            tpcr_pkg::RMS_DONE:
            begin
                state_next = tpcr_pkg::RMS_IDLE;
            end
            default:
            begin
                state_next = tpcr_pkg::RMS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        div_en  = 1'b0;
        root_en = 1'b0;
        done    = 1'b0;
        case (state_reg)
            tpcr_pkg::RMS_DIV:  div_en  = 1'b1;
            tpcr_pkg::RMS_ROOT: root_en = 1'b1;
            tpcr_pkg::RMS_DONE: done    = 1'b1;
            default:            done    = 1'b0;
        endcase
    end

    // restoring divide, one quotient bit per cycle
    assign div_shift = {drem_reg, q_reg[IN_BITS-1]};
    assign div_ge    = (div_shift >= {1'b0, dsor_reg});
    assign div_diff  = div_shift - {1'b0, dsor_reg};

    // square root, one result bit per cycle
    assign root_shift = {srem_reg, q_reg[IN_BITS-1:IN_BITS-2]};
    assign root_trial = {2'b00, root_reg, 2'b01};
    assign root_ge    = (root_shift >= root_trial);
    assign root_diff  = root_shift - root_trial;

    assign root = (root_reg > RS'({tpcr_pkg::RMS_BITS{1'b1}})) ?
                  {tpcr_pkg::RMS_BITS{1'b1}} : root_reg[tpcr_pkg::RMS_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpcr_pkg::RMS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == tpcr_pkg::RMS_IDLE)
        begin
            q_reg    <= IN_BITS'(dividend);
            drem_reg <= '0;
            dsor_reg <= divisor;
            step_reg <= STEP_BITS'(IN_BITS - 1);
        end
        else if (div_en)
        begin
            q_reg    <= {q_reg[IN_BITS-2:0], div_ge};
            drem_reg <= div_ge ? div_diff[CNT_BITS-1:0] : div_shift[CNT_BITS-1:0];
            if (step_last)
            begin
                step_reg <= STEP_BITS'(RS - 1);
                srem_reg <= '0;
                root_reg <= '0;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
        else if (root_en)
        begin
            q_reg    <= {q_reg[IN_BITS-3:0], 2'b00};
            srem_reg <= root_ge ? root_diff[RS+1:0] : root_shift[RS+1:0];
            root_reg <= {root_reg[RS-2:0], root_ge};
            step_reg <= step_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

### test/three_phase_cycle_rms_test.sv
// testbench for three_phase_cycle_rms: wrap-windowed rms beats checked against a predictor
module three_phase_cycle_rms_test;

    localparam longint SUM_LIMIT        = (longint'(1) << tpcr_pkg::SUM_BITS) - 1;
    localparam int     WINDOW_LIMIT     = tpcr_pkg::MAX_WINDOW_DEF;
    localparam int     SETTLE_CYCLES    = 640;
    localparam longint CYCLE_LIMIT      = 3000000;
    localparam int     FULL_SCALE_BEATS = 60;
    localparam int     PHASE_BEATS      = 180;
    localparam int     RANDOM_PHASES    = 6;

    typedef struct {
        logic [tpcr_pkg::FIELD_BITS-1:0]        phase_angle;
        logic signed [tpcr_pkg::FIELD_BITS-1:0] chan [tpcr_pkg::CHANNELS];
    } grid_sample_t;

    typedef struct {
        logic [tpcr_pkg::RMS_BITS-1:0]       rms [tpcr_pkg::CHANNELS];
        logic [tpcr_pkg::COUNT_OUT_BITS-1:0] window_samples;
    } rms_window_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tpcr_in_if  sample_ch ();
    tpcr_out_if result_ch ();
    tpcr_cfg_if cfg_ch ();

    three_phase_cycle_rms i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    string rms_names [tpcr_pkg::CHANNELS] = '{"rms_current_a", "rms_current_b",
                                              "rms_current_c", "rms_voltage_a",
                                              "rms_voltage_b", "rms_voltage_c"};

    logic [tpcr_pkg::FIELD_BITS-1:0] prev_angle;
    logic [tpcr_pkg::FIELD_BITS-1:0] wrap_threshold;
    longint                chan_energy [tpcr_pkg::CHANNELS];
    int                    window_len;
    rms_window_t           pending_windows [$];
    int                    mismatch_count = 0;
    longint                cycle_count = 0;
    bit                    sender_idling = 1'b0;
    bit                    result_stalls = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint floor_root(input longint x);
        longint root;
        longint place;
        root = 0;
        place = longint'(1) << 62;
        while (place > x)
            place = place >> 2;
        while (place != 0)
        begin
            if (x >= root + place)
            begin
                x = x - (root + place);
                root = (root >> 1) + place;
            end
            else
            begin
                root = root >> 1;
            end
            place = place >> 2;
        end
        return root;
    endfunction

    task automatic accumulate_sample(input grid_sample_t s);
        rms_window_t closed;
        longint      divisor;
        longint      root;
        longint      mag;
        longint      sq;
        if (prev_angle > s.phase_angle && (prev_angle - s.phase_angle) > wrap_threshold)
        begin
            divisor = (window_len == 0) ? 1 : window_len;
            for (int i = 0; i < tpcr_pkg::CHANNELS; i++)
            begin
                root = floor_root(chan_energy[i] / divisor);
                closed.rms[i] = (root > 65535) ? 16'hFFFF : root[15:0];
                chan_energy[i] = 0;
            end
            closed.window_samples = divisor[tpcr_pkg::COUNT_OUT_BITS-1:0];
            window_len = 0;
            pending_windows.push_back(closed);
        end
        for (int i = 0; i < tpcr_pkg::CHANNELS; i++)
        begin
            mag = s.chan[i];
            if (mag < 0)
                mag = -mag;
            sq = mag * mag;
            if (sq > SUM_LIMIT - chan_energy[i])
                chan_energy[i] = SUM_LIMIT;
            else
                chan_energy[i] = chan_energy[i] + sq;
        end
        if (window_len < WINDOW_LIMIT)
            window_len++;
        prev_angle = s.phase_angle;
    endtask

    function automatic logic signed [tpcr_pkg::FIELD_BITS-1:0] random_level();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic grid_sample_t make_beat(input int angle, input int c0, input int c1,
                                               input int c2, input int c3, input int c4,
                                               input int c5);
        grid_sample_t s;
        s.phase_angle = angle[15:0];
        s.chan[0] = c0[15:0];
        s.chan[1] = c1[15:0];
        s.chan[2] = c2[15:0];
        s.chan[3] = c3[15:0];
        s.chan[4] = c4[15:0];
        s.chan[5] = c5[15:0];
        return s;
    endfunction

    function automatic grid_sample_t random_beat(input int angle);
        grid_sample_t s;
        s.phase_angle = angle[15:0];
        foreach (s.chan[i])
            s.chan[i] = random_level();
        return s;
    endfunction

    function automatic grid_sample_t full_scale_beat(input int angle);
        grid_sample_t s;
        s.phase_angle = angle[15:0];
        foreach (s.chan[i])
        begin
            case ($urandom_range(0, 2))
                0: s.chan[i] = 16'sh8000;
                1: s.chan[i] = 16'sh7FFF;
                default: s.chan[i] = 16'sh8001;
            endcase
        end
        return s;
    endfunction

    task automatic send_sample(input grid_sample_t s);
        if (sender_idling && $urandom_range(0, 4) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.phase_angle <= s.phase_angle;
        sample_ch.current_a   <= s.chan[0];
        sample_ch.current_b   <= s.chan[1];
        sample_ch.current_c   <= s.chan[2];
        sample_ch.voltage_a   <= s.chan[3];
        sample_ch.voltage_b   <= s.chan[4];
        sample_ch.voltage_c   <= s.chan[5];
        do @(posedge clk); while (!sample_ch.ready);
        accumulate_sample(s);
    endtask

    task automatic drain_windows();
        sample_ch.valid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [tpcr_pkg::FIELD_BITS-1:0] value);
        drain_windows();
        cfg_ch.valid               <= 1'b1;
        cfg_ch.wrap_drop_threshold <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        wrap_threshold = value;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // reset threshold: drops at, just past and far past the threshold
    task automatic test_wrap_detection();
        send_sample(make_beat(0, 0, 0, 0, 0, 0, 0));
        send_sample(make_beat(1000, -32768, 32767, 0, -1, 1, -12345));
        send_sample(make_beat(40000, 32767, -32768, -1, 0, -32768, 32767));
        send_sample(make_beat(65535, -1, 1, -32768, 32767, 0, -32768));
        send_sample(make_beat(32767, -32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(make_beat(65535, 32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(make_beat(32766, 5, -5, 300, -300, 20000, -20000));
        send_sample(make_beat(32766, -32768, 32767, 1, -1, 0, 7));
        send_sample(make_beat(0, 100, 200, 300, -400, -500, -600));
        send_sample(make_beat(65535, -32768, -32768, 32767, 32767, 0, 0));
        send_sample(make_beat(0, 1, 2, 3, 4, 5, 6));
    endtask

    task automatic test_threshold_extremes();
        write_threshold(16'h0000);
        send_sample(make_beat(100, -32768, 32767, -32768, 32767, -32768, 32767));
        send_sample(make_beat(99, 32767, -32768, 32767, -32768, 32767, -32768));
        send_sample(make_beat(99, -1, -1, -1, -1, -1, -1));
        send_sample(make_beat(98, 0, 0, 0, 0, 0, 0));
        send_sample(make_beat(0, 12345, -12345, 1, -1, 32767, -32768));
        write_threshold(16'hFFFF);
        send_sample(make_beat(65535, -32768, 0, 32767, -1, 1, 2));
        send_sample(make_beat(0, 3, -3, 9, -9, 27, -27));
        send_sample(make_beat(65535, 1000, 2000, 3000, 4000, 5000, 6000));
        write_threshold(16'hFFFE);
        send_sample(make_beat(0, -32768, -32768, -32768, 32767, 32767, 32767));
    endtask

    // long window of full-scale samples
    task automatic test_full_scale_window();
        write_threshold(tpcr_pkg::THRESHOLD_RESET);
        send_sample(random_beat(65535));
        send_sample(random_beat(0));
        for (int n = 0; n < FULL_SCALE_BEATS; n++)
            send_sample(full_scale_beat($urandom_range(20000, 40000)));
        send_sample(full_scale_beat(60000));
        send_sample(full_scale_beat(0));
    endtask

    task automatic test_random_windows();
        int thr;
        int slack;
        int sent;
        int kind;
        int len;
        int lo;
        int hi;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: thr = tpcr_pkg::THRESHOLD_RESET;
                2: thr = $urandom_range(0, 255);
                3: thr = $urandom_range(60000, 65000);
                4: thr = $urandom_range(16384, 49152);
                default: thr = $urandom_range(0, 65000);
            endcase
            write_threshold(thr[15:0]);
            sender_idling = (phase != 2 && phase != RANDOM_PHASES - 1);
            result_stalls = sender_idling;
            slack = (65534 - thr) / 2;
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 3)
                begin
                    send_sample(random_beat($urandom_range(0, 65535)));
                    sent++;
                end
                else
                begin
                    len = $urandom_range(2, 10);
                    lo = $urandom_range(0, slack);
                    hi = 65535 - int'($urandom_range(0, slack));
                    // drop exactly at the threshold, or one past it
                    if (kind == 3 && int'(prev_angle) >= thr)
                        lo = int'(prev_angle) - thr;
                    else if (kind == 4 && int'(prev_angle) > thr)
                        lo = int'(prev_angle) - thr - 1;
                    if (hi < lo)
                        hi = lo;
                    for (int k = 0; k < len; k++)
                    begin
                        send_sample(random_beat(lo + (hi - lo) * k / (len - 1)));
                        sent++;
                    end
                end
            end
        end
        sender_idling = 1'b0;
        result_stalls = 1'b0;
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (result_stalls && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rms_window_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (pending_windows.size() == 0)
                begin
                    $error("result beat with no closed window pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_windows.pop_front();
                    check_field(rms_names[0], want.rms[0], result_ch.rms_current_a);
                    check_field(rms_names[1], want.rms[1], result_ch.rms_current_b);
                    check_field(rms_names[2], want.rms[2], result_ch.rms_current_c);
                    check_field(rms_names[3], want.rms[3], result_ch.rms_voltage_a);
                    check_field(rms_names[4], want.rms[4], result_ch.rms_voltage_b);
                    check_field(rms_names[5], want.rms[5], result_ch.rms_voltage_c);
                    check_field("window_samples", want.window_samples,
                                result_ch.window_samples);
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        sample_ch.valid            <= 1'b0;
        sample_ch.phase_angle      <= '0;
        sample_ch.current_a        <= '0;
        sample_ch.current_b        <= '0;
        sample_ch.current_c        <= '0;
        sample_ch.voltage_a        <= '0;
        sample_ch.voltage_b        <= '0;
        sample_ch.voltage_c        <= '0;
        cfg_ch.valid               <= 1'b0;
        cfg_ch.wrap_drop_threshold <= '0;
        wrap_threshold = tpcr_pkg::THRESHOLD_RESET;
        prev_angle = '0;
        window_len = 0;
        foreach (chan_energy[i])
            chan_energy[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_wrap_detection();
        test_threshold_extremes();
        test_full_scale_window();
        test_random_windows();
        drain_windows();
        if (mismatch_count == 0 && pending_windows.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
